// ===== hw/rtl/shri_pkg.sv =====
package shri_pkg;

    // Configuration port
    localparam int unsigned ADDR_W      = 3;
    localparam int unsigned HASH_MODE_W = 2;
    localparam logic [ADDR_W-3:0] REG_HASH_MODE = 1'b0;

    // Hash schemes
    localparam logic [HASH_MODE_W-1:0] MODE_LCG  = 2'd0;
    localparam logic [HASH_MODE_W-1:0] MODE_FMIX = 2'd1;
    localparam logic [HASH_MODE_W-1:0] MODE_XORO = 2'd2;

    // Pipeline depth, input register to output register
    localparam int unsigned PIPE_DEPTH = 12;

    // Hash constants
    localparam logic [63:0] PHI_CONST   = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] PHI_TWICE   = 64'h3C6EF372FE94F82A;
    localparam logic [47:0] LCG_SCRAM   = 48'h0005DEECE66D;
    localparam logic [63:0] LCG_MUL     = 64'h0000BB20B4600A69;
    localparam logic [63:0] LCG_ADD     = 64'h00000040942DE6BA;
    localparam logic [63:0] FMIX_C1     = 64'hFF51AFD7ED558CCD;
    localparam logic [63:0] FMIX_C2     = 64'hC4CEB9FE1A85EC53;
    localparam logic [63:0] MIX_C1      = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_C2      = 64'h94D049BB133111EB;
    localparam logic [63:0] XO_SEED_XOR = 64'h6A09E667F3BCC909;

    typedef struct packed {
        logic                   vld;
        logic [HASH_MODE_W-1:0] mode;
    } stg_ctrl_t;

endpackage

// ===== hw/rtl/seed_hash_random_int.sv =====
// A word accepted at one rising edge passes 12 register stages from input to output
// before it is shown on random_value with done high.
// Throughput: one word per cycle; busy stays low, the pipeline never stalls.
// Reset (rst_n low, asynchronous) clears the stage valid bits and sets hash_mode to 0.
// The receiver cannot stall: every result is shown for exactly one cycle.
module seed_hash_random_int (
    input  logic                        clk,
    input  logic                        rst_n,
    // command channel
    input  logic                        start,
    output logic                        busy,
    input  logic signed [63:0]          seed_value,
    output logic                        done,
    output logic signed [31:0]          random_value,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [shri_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [shri_pkg::HASH_MODE_W-1:0] hash_mode_reg, hash_mode_next;
    logic                             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    // Keep only the low bits of the written word; ignore other addresses
    always_comb
    begin
        hash_mode_next = hash_mode_reg;
        if (cfg_wr && paddr[shri_pkg::ADDR_W-1:2] == shri_pkg::REG_HASH_MODE)
        begin
            hash_mode_next = pwdata[shri_pkg::HASH_MODE_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[shri_pkg::ADDR_W-1:2] == shri_pkg::REG_HASH_MODE)
        begin
            prdata[shri_pkg::HASH_MODE_W-1:0] = hash_mode_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_mode_reg <= shri_pkg::MODE_LCG;
        end
        else
        begin
            hash_mode_reg <= hash_mode_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage control: valid bit and mode travel with each word.
    // Stage 0  input register
    // Stage 1-2  first multiply (LCG step, or fmix C1)
    // Stage 3-4  second multiply (fmix C2); LCG result taken at stage 3
    // Stage 5  lane seeds: fmix+phi pair, or xoroshiro pair
    // Stage 6-9  two mix13 lanes in parallel
    // Stage 10 final xor-shift and lane sum
    // Stage 11 rotate, add and output register
    // ------------------------------------------------------------------
    shri_pkg::stg_ctrl_t ctrl_reg [0:shri_pkg::PIPE_DEPTH-1];
    shri_pkg::stg_ctrl_t ctrl_next[0:shri_pkg::PIPE_DEPTH-1];

    // Every cycle can take a new word
    assign busy = 1'b0;

    always_comb
    begin
        ctrl_next[0].vld  = start & ~busy;
        ctrl_next[0].mode = hash_mode_reg;
        for (int i = 1; i < shri_pkg::PIPE_DEPTH; i++)
        begin
            ctrl_next[i] = ctrl_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < shri_pkg::PIPE_DEPTH; i++)
            begin
                ctrl_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < shri_pkg::PIPE_DEPTH; i++)
            begin
                ctrl_reg[i] <= ctrl_next[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Seed delay line, stages 0 to 4 (the xoroshiro mode needs it at stage 5)
    // ------------------------------------------------------------------
    logic [63:0] seed_reg [0:4];

    always_ff @(posedge clk)
    begin
        seed_reg[0] <= seed_value;
        for (int i = 1; i < 5; i++)
        begin
            seed_reg[i] <= seed_reg[i-1];
        end
    end

    // ------------------------------------------------------------------
    // First multiply: scrambled 48-bit seed by LCG_MUL, or fmix step by C1
    // ------------------------------------------------------------------
    logic [63:0] mul1_a;
    logic [63:0] mul1_k;
    logic [63:0] mul1_p;

    always_comb
    begin
        if (ctrl_reg[0].mode == shri_pkg::MODE_LCG)
        begin
            mul1_a = {16'b0, seed_reg[0][47:0] ^ shri_pkg::LCG_SCRAM};
            mul1_k = shri_pkg::LCG_MUL;
        end
        else
        begin
            mul1_a = seed_reg[0] ^ (seed_reg[0] >> 33);
            mul1_k = shri_pkg::FMIX_C1;
        end
    end

    shri_mul64 u_mul1 (
        .clk (clk),
        .a   (mul1_a),
        .k   (shri_pkg::FMIX_C1 == mul1_k ? shri_pkg::FMIX_C1 : mul1_k),
        .p   (mul1_p)
    );

    // ------------------------------------------------------------------
    // LCG result: add the increment and take bits 16..47; hold to stage 10
    // ------------------------------------------------------------------
    logic [63:0] lcg_sum;
    logic [31:0] lcg_reg [0:7];

    assign lcg_sum = mul1_p + shri_pkg::LCG_ADD;

    always_ff @(posedge clk)
    begin
        lcg_reg[0] <= lcg_sum[47:16];
        for (int i = 1; i < 8; i++)
        begin
            lcg_reg[i] <= lcg_reg[i-1];
        end
    end

    // ------------------------------------------------------------------
    // Second multiply: fmix step by C2
    // ------------------------------------------------------------------
    logic [63:0] mul2_a;
    logic [63:0] mul2_p;

    assign mul2_a = mul1_p ^ (mul1_p >> 33);

    shri_mul64 u_mul2 (
        .clk (clk),
        .a   (mul2_a),
        .k   (shri_pkg::FMIX_C2),
        .p   (mul2_p)
    );

    // ------------------------------------------------------------------
    // Lane seeds at stage 5
    // ------------------------------------------------------------------
    logic [63:0] fmix_out;
    logic [63:0] xo_lo;
    logic [63:0] lane_lo_reg, lane_lo_next;
    logic [63:0] lane_hi_reg, lane_hi_next;

    assign fmix_out = mul2_p ^ (mul2_p >> 33);
    assign xo_lo    = seed_reg[4] ^ shri_pkg::XO_SEED_XOR;

    // fmix mode: lanes get v and v + phi, where v is already fmix + phi
    always_comb
    begin
        if (ctrl_reg[4].mode == shri_pkg::MODE_XORO)
        begin
            lane_lo_next = xo_lo;
            lane_hi_next = xo_lo + shri_pkg::PHI_CONST;
        end
        else
        begin
            lane_lo_next = fmix_out + shri_pkg::PHI_CONST;
            lane_hi_next = fmix_out + shri_pkg::PHI_TWICE;
        end
    end

    always_ff @(posedge clk)
    begin
        lane_lo_reg <= lane_lo_next;
        lane_hi_reg <= lane_hi_next;
    end

    // ------------------------------------------------------------------
    // Two mix13 lanes, stages 6 to 9
    // ------------------------------------------------------------------
    logic [63:0] mix_lo;
    logic [63:0] mix_hi;

    shri_mix_lane u_lane_lo (
        .clk (clk),
        .v   (lane_lo_reg),
        .m   (mix_lo)
    );

    shri_mix_lane u_lane_hi (
        .clk (clk),
        .v   (lane_hi_reg),
        .m   (mix_hi)
    );

    // ------------------------------------------------------------------
    // Stage 10: finish both mixes and add them
    // ------------------------------------------------------------------
    logic [63:0] fin_lo;
    logic [63:0] fin_hi;
    logic [63:0] sum_reg, sum_next;
    logic [31:0] alo_reg, alo_next;

    assign fin_lo   = mix_lo ^ (mix_lo >> 31);
    assign fin_hi   = mix_hi ^ (mix_hi >> 31);
    assign sum_next = fin_lo + fin_hi;
    assign alo_next = fin_lo[31:0];

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        alo_reg <= alo_next;
    end

    // ------------------------------------------------------------------
    // Stage 11: select per mode. Low word of rotl(sum, 17) is
    // sum[14:0] above sum[63:47].
    // ------------------------------------------------------------------
    logic [31:0] rot_lo;
    logic [31:0] random_value_reg, random_value_next;

    assign rot_lo = {sum_reg[14:0], sum_reg[63:47]};

    always_comb
    begin
        case (ctrl_reg[10].mode)
            shri_pkg::MODE_LCG:  random_value_next = lcg_reg[7];
            shri_pkg::MODE_FMIX: random_value_next = sum_reg[31:0];
            shri_pkg::MODE_XORO: random_value_next = rot_lo + alo_reg;
            default:             random_value_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        random_value_reg <= random_value_next;
    end

    assign random_value = random_value_reg;
    assign done         = ctrl_reg[shri_pkg::PIPE_DEPTH-1].vld;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Every result traces back to a word accepted exactly one pipeline depth earlier
    a_done_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, shri_pkg::PIPE_DEPTH))
        else $error("result without a matching accepted word");

    // The unused mode yields zero, judged by the mode in force at acceptance
    a_unused_mode_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(hash_mode_reg, shri_pkg::PIPE_DEPTH) != shri_pkg::MODE_LCG
              && $past(hash_mode_reg, shri_pkg::PIPE_DEPTH) != shri_pkg::MODE_FMIX
              && $past(hash_mode_reg, shri_pkg::PIPE_DEPTH) != shri_pkg::MODE_XORO)
        |-> random_value == 32'sd0)
        else $error("unused hash mode gave a non-zero result");

    // Mode carried with the word matches the register at acceptance
    a_mode_carried: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ctrl_reg[shri_pkg::PIPE_DEPTH-1].mode
                 == $past(hash_mode_reg, shri_pkg::PIPE_DEPTH))
        else $error("hash mode lost on its way through the pipeline");

endmodule

// ===== hw/rtl/shri_mul64.sv =====
// Low 64 bits of a 64 x 64 product over two stages: partial products, then sum.
module shri_mul64 (
    input  logic        clk,
    input  logic [63:0] a,
    input  logic [63:0] k,
    output logic [63:0] p
);

    logic [63:0] pp_ll_reg, pp_ll_next;
    logic [31:0] pp_lh_reg, pp_lh_next;
    logic [31:0] pp_hl_reg, pp_hl_next;
    logic [63:0] p_reg, p_next;

    // Cross terms only reach the upper half, so keep their low 32 bits
    always_comb
    begin
        pp_ll_next = 64'(a[31:0]) * 64'(k[31:0]);
        pp_lh_next = a[31:0] * k[63:32];
        pp_hl_next = a[63:32] * k[31:0];
        p_next     = pp_ll_reg + {pp_lh_reg + pp_hl_reg, 32'b0};
    end

    always_ff @(posedge clk)
    begin
        pp_ll_reg <= pp_ll_next;
        pp_lh_reg <= pp_lh_next;
        pp_hl_reg <= pp_hl_next;
        p_reg     <= p_next;
    end

    assign p = p_reg;

endmodule

// ===== hw/rtl/shri_mix_lane.sv =====
// Stafford variant 13 mixer up to the last xor-shift: four register stages.
module shri_mix_lane (
    input  logic        clk,
    input  logic [63:0] v,
    output logic [63:0] m
);

    logic [63:0] x1;
    logic [63:0] p1;
    logic [63:0] x2;

    assign x1 = v ^ (v >> 30);

    shri_mul64 u_mul_c1 (
        .clk (clk),
        .a   (x1),
        .k   (shri_pkg::MIX_C1),
        .p   (p1)
    );

    assign x2 = p1 ^ (p1 >> 27);

    shri_mul64 u_mul_c2 (
        .clk (clk),
        .a   (x2),
        .k   (shri_pkg::MIX_C2),
        .p   (m)
    );

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

    // Run limits
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned PHASE_WORDS  = 240;
    localparam int unsigned IDLE_PERCENT = 21;

    // Register map: hash_mode at index 0, index 1 is unmapped
    localparam logic [shri_pkg::ADDR_W-3:0] REG_UNMAPPED = 1'b1;

    // The fourth mode selects no hash at all
    localparam logic [shri_pkg::HASH_MODE_W-1:0] MODE_SPARE = 2'd3;

    // Hash constants, kept here so that the prediction does not lean on the package
    localparam logic [63:0] H_PHI       = 64'h9E3779B97F4A7C15;
    localparam logic [47:0] H_LCG_SCRAM = 48'h0005DEECE66D;
    localparam logic [63:0] H_LCG_MUL   = 64'h0000BB20B4600A69;
    localparam logic [63:0] H_LCG_ADD   = 64'h00000040942DE6BA;
    localparam logic [63:0] H_FMIX_C1   = 64'hFF51AFD7ED558CCD;
    localparam logic [63:0] H_FMIX_C2   = 64'hC4CEB9FE1A85EC53;
    localparam logic [63:0] H_MIX_C1    = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] H_MIX_C2    = 64'h94D049BB133111EB;
    localparam logic [63:0] H_XO_XOR    = 64'h6A09E667F3BCC909;

    // Scoreboard: predicts the hash of every accepted seed and checks the results in order
    class hash_scoreboard;
        logic [shri_pkg::HASH_MODE_W-1:0] hash_mode;
        logic [31:0]                      expected_q[$];
        int unsigned                      failures;

        function new();
            hash_mode = shri_pkg::MODE_LCG;
            failures  = 0;
        endfunction

        // splitmix64 finaliser, Stafford variant 13
        function logic [63:0] stafford_mix(logic [63:0] x);
            logic [63:0] v;
            v = (x ^ (x >> 30)) * H_MIX_C1;
            v = (v ^ (v >> 27)) * H_MIX_C2;
            return v ^ (v >> 31);
        endfunction

        function logic [31:0] hash_of(logic [63:0] seed);
            logic [63:0] v;
            logic [63:0] a;
            logic [63:0] s;
            case (hash_mode)
                shri_pkg::MODE_LCG:
                begin
                    v = {16'd0, seed[47:0] ^ H_LCG_SCRAM};
                    v = v * H_LCG_MUL + H_LCG_ADD;
                    return v[47:16];
                end
                shri_pkg::MODE_FMIX:
                begin
                    v = seed;
                    v = v ^ (v >> 33);
                    v = v * H_FMIX_C1;
                    v = v ^ (v >> 33);
                    v = v * H_FMIX_C2;
                    v = v ^ (v >> 33);
                    v = v + H_PHI;
                    s = stafford_mix(v) + stafford_mix(v + H_PHI);
                    return s[31:0];
                end
                shri_pkg::MODE_XORO:
                begin
                    v = seed ^ H_XO_XOR;
                    a = stafford_mix(v);
                    s = a + stafford_mix(v + H_PHI);
                    v = {s[46:0], s[63:47]} + a;
                    return v[31:0];
                end
                default:
                    return 32'd0;
            endcase
        endfunction

        function void note_seed(logic [63:0] seed);
            expected_q.push_back(hash_of(seed));
        endfunction

        function void check_result(logic [31:0] got);
            logic [31:0] want;
            if (expected_q.size() == 0)
            begin
                $error("random_value: expected nothing, actual 'h%08h", got);
                failures++;
                return;
            end
            want = expected_q.pop_front();
            if (got !== want)
            begin
                $error("random_value: expected 'h%08h, actual 'h%08h", want, got);
                failures++;
            end
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic signed [63:0]            seed_value;
    logic                          done;
    logic signed [31:0]            random_value;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [shri_pkg::ADDR_W-1:0]   paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;

    hash_scoreboard sb;
    int unsigned    idle_pct;
    int unsigned    cycle_count;
    logic [63:0]    edge_seeds [6];
    logic [shri_pkg::HASH_MODE_W-1:0] phase_modes [8];

    seed_hash_random_int dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .seed_value   (seed_value),
        .done         (done),
        .random_value (random_value),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // Hard stop: a run that reaches CYCLE_LIMIT is reported as broken
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Watch both sides of the block at every rising edge. Values read here are the
    // ones that stood before the edge, so the order of events in the step is irrelevant.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(random_value);
            if (start && !busy)
                sb.note_seed(seed_value);
        end
    end

    // Offer one seed word, idling first at random, and return at the edge that takes it.
    // start is left high so that a back-to-back word needs no second assignment.
    task automatic send_seed(input logic [63:0] s);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        seed_value <= s;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Drop start and hold until every predicted word has come out, then let the
    // pipeline run dry for good measure.
    task automatic drain_results();
        start <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (shri_pkg::PIPE_DEPTH + 2)
            @(posedge clk);
    endtask

    // Write a register in a setup and an access cycle, then read hash_mode back.
    task automatic write_reg(input logic [shri_pkg::ADDR_W-3:0] index,
                             input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        // Only the low bits of the mode register survive; other indexes are dropped
        if (index == shri_pkg::REG_HASH_MODE)
            sb.hash_mode = value[shri_pkg::HASH_MODE_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        psel    <= 1'b1;
        paddr   <= {shri_pkg::REG_HASH_MODE, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== {{(32 - shri_pkg::HASH_MODE_W){1'b0}}, sb.hash_mode})
        begin
            $error("hash_mode: expected %0d, actual 'h%08h", sb.hash_mode, prdata);
            sb.failures++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Random seeds, biased towards the corners each hash is touchy about
    function automatic logic [63:0] pick_seed();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(9))
            0: return 64'($urandom_range(255));
            1: return -64'($urandom_range(256));
            2: return 64'd1 << $urandom_range(63);
            3: return ~(64'd1 << $urandom_range(63));
            4: return {16'd0, r[47:0]};
            5: return r ^ {16'd0, H_LCG_SCRAM} ^ 64'($urandom_range(15));
            default: return r;
        endcase
    endfunction

    initial
    begin
        sb          = new();
        idle_pct    = IDLE_PERCENT;
        rst_n      <= 1'b0;
        start      <= 1'b0;
        seed_value <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;

        // Corner seeds: zero, all ones, the signed extremes, a seed that cancels the
        // LCG scramble and one that zeroes the low word of the xoroshiro seeding
        edge_seeds[0] = 64'h0000000000000000;
        edge_seeds[1] = 64'hFFFFFFFFFFFFFFFF;
        edge_seeds[2] = 64'h8000000000000000;
        edge_seeds[3] = 64'h7FFFFFFFFFFFFFFF;
        edge_seeds[4] = {16'd0, H_LCG_SCRAM};
        edge_seeds[5] = H_XO_XOR;

        phase_modes[0] = shri_pkg::MODE_XORO;
        phase_modes[1] = shri_pkg::MODE_LCG;
        phase_modes[2] = shri_pkg::MODE_FMIX;
        phase_modes[3] = MODE_SPARE;
        phase_modes[4] = shri_pkg::MODE_FMIX;
        phase_modes[5] = shri_pkg::MODE_XORO;
        phase_modes[6] = shri_pkg::MODE_LCG;
        phase_modes[7] = shri_pkg::MODE_XORO;

        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: corner seeds under the reset mode first
        foreach (edge_seeds[k])
            send_seed(edge_seeds[k]);
        drain_results();

        write_reg(shri_pkg::REG_HASH_MODE,
                  {{(32 - shri_pkg::HASH_MODE_W){1'b0}}, shri_pkg::MODE_FMIX});
        foreach (edge_seeds[k])
            send_seed(edge_seeds[k]);
        drain_results();

        write_reg(shri_pkg::REG_HASH_MODE,
                  {{(32 - shri_pkg::HASH_MODE_W){1'b0}}, shri_pkg::MODE_XORO});
        foreach (edge_seeds[k])
            send_seed(edge_seeds[k]);
        drain_results();

        // Over-wide write lands on the unused mode; the unmapped write must not disturb it
        write_reg(shri_pkg::REG_HASH_MODE, 32'hFFFF_FFFF);
        write_reg(REG_UNMAPPED, {{(32 - shri_pkg::HASH_MODE_W){1'b0}}, shri_pkg::MODE_FMIX});
        foreach (edge_seeds[k])
            send_seed(edge_seeds[k]);
        drain_results();

        // Random part: one mode per phase, junk in the upper bits of every write
        foreach (phase_modes[p])
        begin
            write_reg(shri_pkg::REG_HASH_MODE,
                      {(32 - shri_pkg::HASH_MODE_W)'($urandom_range(32'h3FFF_FFFF)),
                       phase_modes[p]});
            // Run phase 4 back to back, with no idling at all; the other phases idle at random
            idle_pct = (p == 4) ? 0 : IDLE_PERCENT;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                // Hold off halfway through the first phase until the pipeline is empty
                if (p == 0 && n == PHASE_WORDS / 2)
                    drain_results();
                send_seed(pick_seed());
            end
            drain_results();
        end

        if (sb.failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
